// ----- design/tpdr_pkg.sv -----
// Shared constants, codes and control types for the two-part datagram reassembly core.
package tpdr_pkg;

   localparam int SLOTS_DEF         = 4;
   localparam int LEN_BITS_DEF      = 11;
   localparam int MAX_PAYLOAD_RESET = 1500;

   localparam int KIND_BITS   = 8;
   localparam int SOURCE_BITS = 32;
   localparam int TAG_BITS    = 8;
   localparam int HANDLE_BITS = 8;
   localparam int ACT_BITS    = 2;

   // frame kinds
   localparam logic [KIND_BITS-1:0] KIND_WHOLE  = 8'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIRST  = 8'd1;
   localparam logic [KIND_BITS-1:0] KIND_SECOND = 8'd2;

   // result actions
   localparam logic [ACT_BITS-1:0] ACT_SINGLE  = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_PAIR    = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_RELEASE = 2'd2;

   // result field selection
   localparam logic [1:0] EM_SINGLE   = 2'd0;
   localparam logic [1:0] EM_SLOT_REL = 2'd1;
   localparam logic [1:0] EM_PAIR     = 2'd2;
   localparam logic [1:0] EM_ITEM_REL = 2'd3;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic [1:0] emit_code;
      logic       emit_last;
      logic       invalidate;
      logic       store;
      logic       bump_ptr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic kind_whole;
      logic kind_first;
      logic kind_second;
      logic hit;
      logic tag_match;
      logic over_limit;
      logic free_any;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/tpdr_if.sv -----
// Handshake interfaces for the request, response and register write channels.
interface tpdr_req_if import tpdr_pkg::*; #(
   parameter int LEN_BITS = LEN_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   frame_kind;
   logic [SOURCE_BITS-1:0] source_addr;
   logic [TAG_BITS-1:0]    seq_tag;
   logic [LEN_BITS-1:0]    payload_len;
   logic [HANDLE_BITS-1:0] buffer_handle;

   modport source (output valid, frame_kind, source_addr, seq_tag, payload_len,
                   buffer_handle, input ready);
   modport sink (input valid, frame_kind, source_addr, seq_tag, payload_len,
                 buffer_handle, output ready);
endinterface

interface tpdr_rsp_if import tpdr_pkg::*; #(
   parameter int LEN_BITS = LEN_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic [ACT_BITS-1:0]    action;
   logic [HANDLE_BITS-1:0] first_handle;
   logic [HANDLE_BITS-1:0] second_handle;
   logic [LEN_BITS-1:0]    total_len;
   logic                   last;

   modport source (output valid, action, first_handle, second_handle, total_len, last,
                   input ready);
   modport sink (input valid, action, first_handle, second_handle, total_len, last,
                 output ready);
endinterface

interface tpdr_csr_if import tpdr_pkg::*; #(
   parameter int LEN_BITS = LEN_BITS_DEF
);
   logic                valid;
   logic                ready;
   logic [LEN_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- design/tpdr_ctrl.sv -----
// Sequencer: decodes request kind, walks the slot table one entry per cycle unless output stalls.
module tpdr_ctrl import tpdr_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_accept,
   output logic                                req_ready,
   input  dp_status_type                       status,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] free_idx,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] evict_ptr,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot_idx,
   output ctrl_cmd_type                        cmd
);

   localparam int IDX_BITS = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN1  = 3'd2;
   localparam logic [2:0] ST_PLACE  = 3'd3;
   localparam logic [2:0] ST_EVICT  = 3'd4;
   localparam logic [2:0] ST_SCAN2  = 3'd5;
   localparam logic [2:0] ST_FINAL  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_idx  = (state_ff == ST_PLACE && status.free_any) ? free_idx : idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            idx_in = '0;
            if (status.kind_whole) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_code = EM_SINGLE;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.kind_first) begin
               state_in = ST_SCAN1;
            end else if (status.kind_second) begin
               state_in = ST_SCAN2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN1: begin
            // only one entry per source can be held, so its release frees a slot and ends output
            if (!status.hit || status.out_free) begin
               if (status.hit) begin
                  cmd.emit       = 1'b1;
                  cmd.emit_code  = EM_SLOT_REL;
                  cmd.emit_last  = 1'b1;
                  cmd.invalidate = 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_PLACE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_PLACE: begin
            if (status.free_any) begin
               cmd.store = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = evict_ptr;
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = EM_SLOT_REL;
               cmd.emit_last = 1'b1;
               cmd.store     = 1'b1;
               cmd.bump_ptr  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN2: begin
            if (!status.hit) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FINAL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.invalidate = 1'b1;
               if (status.tag_match) begin
                  cmd.emit_code = status.over_limit ? EM_SLOT_REL : EM_PAIR;
                  state_in      = ST_FINAL;
               end else begin
                  cmd.emit_code = EM_SLOT_REL;
                  if (idx_ff == LAST_IDX) begin
                     state_in = ST_FINAL;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = EM_ITEM_REL;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/tpdr_dp.sv -----
// Datapath: request latch, slot table, limit register, compare logic and response register.
module tpdr_dp import tpdr_pkg::*; #(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int LEN_BITS = LEN_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [KIND_BITS-1:0]                frame_kind,
   input  logic [SOURCE_BITS-1:0]              source_addr,
   input  logic [TAG_BITS-1:0]                 seq_tag,
   input  logic [LEN_BITS-1:0]                 payload_len,
   input  logic [HANDLE_BITS-1:0]              buffer_handle,
   input  ctrl_cmd_type                        cmd,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] slot_idx,
   output dp_status_type                       status,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] free_idx,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] evict_ptr,
   tpdr_rsp_if.source                          rsp_bus,
   tpdr_csr_if.sink                            csr_bus
);

   localparam int IDX_BITS = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int LEN_MAX  = (1 << LEN_BITS) - 1;
   localparam logic [LEN_BITS-1:0] MAX_RESET =
      LEN_BITS'((MAX_PAYLOAD_RESET > LEN_MAX) ? LEN_MAX : MAX_PAYLOAD_RESET);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SLOTS - 1);

   // latched request
   logic [KIND_BITS-1:0]   kind_ff;
   logic [SOURCE_BITS-1:0] src_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic [LEN_BITS-1:0]    len_ff;
   logic [HANDLE_BITS-1:0] hdl_ff;

   // slot table
   logic [SLOTS-1:0]       slot_valid_ff;
   logic [SOURCE_BITS-1:0] slot_source_ff [SLOTS];
   logic [TAG_BITS-1:0]    slot_tag_ff    [SLOTS];
   logic [LEN_BITS-1:0]    slot_length_ff [SLOTS];
   logic [HANDLE_BITS-1:0] slot_handle_ff [SLOTS];
   logic [IDX_BITS-1:0]    ptr_ff;
   logic [LEN_BITS-1:0]    max_payload_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ACT_BITS-1:0]    action_ff, action_in;
   logic [HANDLE_BITS-1:0] first_ff, first_in;
   logic [HANDLE_BITS-1:0] second_ff, second_in;
   logic [LEN_BITS-1:0]    total_ff, total_in;
   logic                   last_ff;

   logic [LEN_BITS:0]      sum;
   logic [HANDLE_BITS-1:0] rd_handle;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= frame_kind;
         src_ff  <= source_addr;
         tag_ff  <= seq_tag;
         len_ff  <= payload_len;
         hdl_ff  <= buffer_handle;
      end
      if (cmd.store) begin
         slot_source_ff[slot_idx] <= src_ff;
         slot_tag_ff[slot_idx]    <= tag_ff;
         slot_length_ff[slot_idx] <= len_ff;
         slot_handle_ff[slot_idx] <= hdl_ff;
      end
      if (cmd.emit) begin
         action_ff <= action_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         total_ff  <= total_in;
         last_ff   <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff  <= '0;
         ptr_ff         <= '0;
         max_payload_ff <= MAX_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.invalidate) begin
            slot_valid_ff[slot_idx] <= 1'b0;
         end
         if (cmd.store) begin
            slot_valid_ff[slot_idx] <= 1'b1;
         end
         if (cmd.bump_ptr) begin
            ptr_ff <= (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
         end
         if (csr_bus.valid) begin
            max_payload_ff <= csr_bus.data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_bus.ready);

   assign rd_handle = slot_handle_ff[slot_idx];
   assign sum       = {1'b0, slot_length_ff[slot_idx]} + {1'b0, len_ff};

   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      action_in = ACT_RELEASE;
      first_in  = hdl_ff;
      second_in = '0;
      total_in  = '0;
      case (cmd.emit_code)
         EM_SINGLE: begin
            action_in = ACT_SINGLE;
            total_in  = len_ff;
         end
         EM_SLOT_REL: begin
            first_in = rd_handle;
         end
         EM_PAIR: begin
            action_in = ACT_PAIR;
            first_in  = rd_handle;
            second_in = hdl_ff;
            total_in  = sum[LEN_BITS-1:0];
         end
         default: begin
            first_in = hdl_ff;
         end
      endcase
   end

   assign status.kind_whole  = (kind_ff == KIND_WHOLE);
   assign status.kind_first  = (kind_ff == KIND_FIRST);
   assign status.kind_second = (kind_ff == KIND_SECOND);
   assign status.hit         = slot_valid_ff[slot_idx] && (slot_source_ff[slot_idx] == src_ff);
   assign status.tag_match   = (slot_tag_ff[slot_idx] == tag_ff);
   assign status.over_limit  = (sum > {1'b0, max_payload_ff});
   assign status.free_any    = ~&slot_valid_ff;
   assign status.out_free    = ~rsp_valid_ff | rsp_bus.ready;
   assign evict_ptr          = ptr_ff;

   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.action        = action_ff;
   assign rsp_bus.first_handle  = first_ff;
   assign rsp_bus.second_handle = second_ff;
   assign rsp_bus.total_len     = total_ff;
   assign rsp_bus.last          = last_ff;

endmodule

// ----- design/two_part_datagram_reassembly_core.sv -----
// A whole datagram is latched, decoded and answered from the response register; a first or
// second half is latched, decoded, walked through the slot table and then placed or given its
// final release, with an eviction step when a first half finds no free slot. Each response
// waits while the output register is full. One request at a time; the next request is taken
// once the sequencer is idle.
// Reset (synchronous, active high) empties the slot table, zeroes the eviction pointer and
// loads the payload limit with 1500.
module two_part_datagram_reassembly_core import tpdr_pkg::*; #(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int LEN_BITS = LEN_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tpdr_req_if.sink   req_bus,
   tpdr_rsp_if.source rsp_bus,
   tpdr_csr_if.sink   csr_bus
);

   localparam int IDX_BITS = SLOTS > 1 ? $clog2(SLOTS) : 1;

   ctrl_cmd_type        cmd;
   dp_status_type       status;
   logic [IDX_BITS-1:0] slot_idx;
   logic [IDX_BITS-1:0] free_idx;
   logic [IDX_BITS-1:0] evict_ptr;
   logic                req_ready;
   logic                req_accept;

   assign req_bus.ready = req_ready;
   assign req_accept    = req_bus.valid & req_ready;

   tpdr_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_ready  (req_ready),
      .status     (status),
      .free_idx   (free_idx),
      .evict_ptr  (evict_ptr),
      .slot_idx   (slot_idx),
      .cmd        (cmd)
   );

   tpdr_dp #(
      .SLOTS    (SLOTS),
      .LEN_BITS (LEN_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .frame_kind    (req_bus.frame_kind),
      .source_addr   (req_bus.source_addr),
      .seq_tag       (req_bus.seq_tag),
      .payload_len   (req_bus.payload_len),
      .buffer_handle (req_bus.buffer_handle),
      .cmd           (cmd),
      .slot_idx      (slot_idx),
      .status        (status),
      .free_idx      (free_idx),
      .evict_ptr     (evict_ptr),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus)
   );

endmodule
